// ----- rtl/nts_extension_field_checker_macros.svh -----
// Assertion macros for the NTS extension field checker
`ifndef NTS_EXTENSION_FIELD_CHECKER_MACROS_SVH
`define NTS_EXTENSION_FIELD_CHECKER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define NEFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define NEFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/nefc_pkg.sv -----
// Shared types and constants for the NTS extension field checker
package nefc_pkg;

    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_SHORT         = 4'd1,
        ST_BAD_LENGTH    = 4'd2,
        ST_OVERRUN       = 4'd3,
        ST_ID_SHORT      = 4'd4,
        ST_ID_MISMATCH   = 4'd5,
        ST_NO_ID         = 4'd6,
        ST_NO_AUTH       = 4'd7,
        ST_TRAILING      = 4'd8,
        ST_AUTH_SHORT    = 4'd9,
        ST_NONCE_SHORT   = 4'd10,
        ST_CT_SHORT      = 4'd11,
        ST_BODY_OVERFLOW = 4'd12,
        ST_PT_TOO_BIG    = 4'd13,
        ST_TOO_LONG      = 4'd14
    } status_t;

    typedef enum logic [2:0] {
        CFG_ID_WORD0  = 3'd0,
        CFG_ID_WORD1  = 3'd1,
        CFG_ID_WORD2  = 3'd2,
        CFG_ID_WORD3  = 3'd3,
        CFG_ID_TYPE   = 3'd4,
        CFG_AUTH_TYPE = 3'd5
    } cfg_index_t;

    localparam logic [15:0] HEADER_SKIP      = 16'd48;
    localparam logic [15:0] MAX_PACKET_BYTES = 16'd4096;
    localparam logic [15:0] PLAINTEXT_LIMIT  = 16'd1024;
    localparam logic [15:0] FIELD_HDR_BYTES  = 16'd4;
    localparam logic [15:0] ID_VALUE_END     = 16'd36;
    localparam logic [15:0] ID_MIN_TOTAL     = 16'd36;
    localparam logic [15:0] AUTH_LEN_END     = 16'd8;
    localparam logic [15:0] AUTH_MIN_TOTAL   = 16'd12;
    localparam logic [15:0] NONCE_MIN        = 16'd16;
    localparam logic [15:0] TAG_BYTES        = 16'd16;
    localparam logic [15:0] ID_TYPE_RESET    = 16'd260;
    localparam logic [15:0] AUTH_TYPE_RESET  = 16'd1028;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] auth_offset;
        logic [15:0] nonce_length;
        logic [15:0] ciphertext_length;
        logic [15:0] ciphertext_offset;
        logic [15:0] packet_length;
    } result_item_t;

    typedef struct packed {
        logic [3:0][63:0] id_word;
        logic [15:0]      id_type;
        logic [15:0]      auth_type;
    } cfg_t;

    // What the front hands the back at the end of a packet
    typedef struct packed {
        status_t     first_error;
        logic [15:0] packet_length;
        logic        seen_id;
        logic        seen_auth;
        logic [15:0] field_start;
        logic [15:0] field_total;
        logic [15:0] nonce_length;
        logic [15:0] ciphertext_length;
        logic [15:0] auth_start;
    } summary_t;

endpackage

// ----- rtl/nts_extension_field_checker.sv -----
// NTS response extension field checker: top level
//
// Usage: packet bytes enter on the byte channel (byte_valid, byte_stall, byte_data), one
// byte per transfer, with final_byte set on the last byte of each packet. The walker
// takes one byte every cycle unless the queue is full; its per-byte state update is the
// only loop. Every packet gives exactly one result on the result channel (result_valid,
// result_stall, result_data), carrying the status, the authenticator offsets and lengths,
// and the packet length.
// At the edge that transfers the final byte the summary is written into the queue; the
// result is then loaded into the output register once that register is free.
// Throughput: one byte per cycle while the queue has room, sustained across packets.
// When the receiver stalls, the result holds in the output register and further packet
// summaries gather in a QUEUE_DEPTH-entry queue; the byte channel keeps flowing and
// asserts byte_stall only once that queue is full.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken,
// and belong in idle periods; indexes past the authenticator type are ignored.
// Reset clears the walker, queue pointers and output valid and loads default type codes.
`include "nts_extension_field_checker_macros.svh"

module nts_extension_field_checker #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_stall,
    input  nefc_pkg::byte_item_t   byte_data,
    output logic                   result_valid,
    input  logic                   result_stall,
    output nefc_pkg::result_item_t result_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);

    nefc_pkg::cfg_t     cfg_reg, cfg_next;
    logic               push, pop, queue_full, head_valid;
    nefc_pkg::summary_t push_data, head_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                nefc_pkg::CFG_ID_WORD0:  cfg_next.id_word[0] = cfg_data;
                nefc_pkg::CFG_ID_WORD1:  cfg_next.id_word[1] = cfg_data;
                nefc_pkg::CFG_ID_WORD2:  cfg_next.id_word[2] = cfg_data;
                nefc_pkg::CFG_ID_WORD3:  cfg_next.id_word[3] = cfg_data;
                nefc_pkg::CFG_ID_TYPE:   cfg_next.id_type    = cfg_data[15:0];
                nefc_pkg::CFG_AUTH_TYPE: cfg_next.auth_type  = cfg_data[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.id_word   <= '0;
            cfg_reg.id_type   <= nefc_pkg::ID_TYPE_RESET;
            cfg_reg.auth_type <= nefc_pkg::AUTH_TYPE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nefc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .cfg        (cfg_reg),
        .queue_full (queue_full),
        .push       (push),
        .summary    (push_data)
    );

    nefc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    nefc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (head_valid),
        .entry        (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    `NEFC_ASSERT_NEXT(a_push_lands, push, head_valid, "packet summary lost in queue")
    `NEFC_ASSERT_NEXT(a_pop_shows, pop, result_valid, "popped summary not presented")
    `NEFC_ASSERT_NOW(a_err_zeroes, result_valid && (result_data.status != nefc_pkg::ST_OK), (result_data.auth_offset == 16'd0) && (result_data.nonce_length == 16'd0) && (result_data.ciphertext_length == 16'd0) && (result_data.ciphertext_offset == 16'd0), "error result carries offsets")
    `NEFC_ASSERT_NOW(a_ok_lengths, result_valid && (result_data.status == nefc_pkg::ST_OK), (result_data.nonce_length >= nefc_pkg::NONCE_MIN) && (result_data.ciphertext_length >= nefc_pkg::TAG_BYTES) && (result_data.packet_length > result_data.auth_offset), "ok result with bad lengths")

endmodule

// ----- rtl/nefc_front.sv -----
// Byte-rate field walker: tracks field headers, identifier match and authenticator
module nefc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  nefc_pkg::byte_item_t byte_data,
    input  nefc_pkg::cfg_t       cfg,
    input  logic                 queue_full,
    output logic                 push,
    output nefc_pkg::summary_t   summary
);

    logic                accept;
    logic [7:0]          b;
    logic [15:0]         pos_reg, pos_next, pos_inc;
    logic [15:0]         start_reg, start_next;
    logic [15:0]         offset_reg, offset_next;
    logic [15:0]         auth_start_reg, auth_start_next;
    logic [31:0]         header_reg, header_next, cur_header;
    logic [31:0]         auth_len_reg, auth_len_next;
    logic                in_id_reg, in_id_next;
    logic                id_diff_reg, id_diff_next;
    logic                seen_id_reg, seen_id_next;
    logic                seen_auth_reg, seen_auth_next;
    nefc_pkg::status_t   error_reg, error_next;
    logic                walk, hdr_byte, hdr_done, bad_len, in_id_now, is_auth;
    logic                id_byte_ne, diff_now, field_end;
    logic [15:0]         field_len;
    logic [4:0]          id_k;
    logic [7:0]          exp_byte;

    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;
    assign push       = accept && byte_data.final_byte;
    assign b          = byte_data.data_byte;

    always_comb
    begin
        pos_inc    = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
        walk       = (pos_reg < nefc_pkg::MAX_PACKET_BYTES) && (error_reg == nefc_pkg::ST_OK)
                     && !seen_auth_reg && (pos_reg >= nefc_pkg::HEADER_SKIP);
        hdr_byte   = offset_reg < nefc_pkg::FIELD_HDR_BYTES;
        hdr_done   = offset_reg == nefc_pkg::FIELD_HDR_BYTES - 16'd1;
        cur_header = hdr_byte ? {header_reg[23:0], b} : header_reg;
        field_len  = cur_header[15:0];
        bad_len    = (field_len < nefc_pkg::FIELD_HDR_BYTES) || (field_len[1:0] != 2'b00);
        in_id_now  = hdr_done ? (cur_header[31:16] == cfg.id_type) : in_id_reg;
        is_auth    = !in_id_now && (cur_header[31:16] == cfg.auth_type);
        id_k       = offset_reg[4:0] - 5'd4;
        exp_byte   = cfg.id_word[id_k[4:3]][{~id_k[2:0], 3'b000} +: 8];
        id_byte_ne = in_id_now && !hdr_byte && (offset_reg < nefc_pkg::ID_VALUE_END)
                     && (b != exp_byte);
        diff_now   = (hdr_done ? 1'b0 : id_diff_reg) | id_byte_ne;
        field_end  = offset_reg == field_len - 16'd1;

        pos_next        = pos_reg;
        start_next      = start_reg;
        offset_next     = offset_reg;
        auth_start_next = auth_start_reg;
        header_next     = header_reg;
        auth_len_next   = auth_len_reg;
        in_id_next      = in_id_reg;
        id_diff_next    = id_diff_reg;
        seen_id_next    = seen_id_reg;
        seen_auth_next  = seen_auth_reg;
        error_next      = error_reg;

        if (accept)
        begin
            pos_next = pos_inc;
            if (pos_reg >= nefc_pkg::MAX_PACKET_BYTES)
            begin
                if (error_reg == nefc_pkg::ST_OK)
                begin
                    error_next = nefc_pkg::ST_TOO_LONG;
                end
            end
            else if (walk)
            begin
                offset_next = offset_reg + 16'd1;
                if (hdr_byte)
                begin
                    header_next = cur_header;
                end
                if (hdr_done && bad_len)
                begin
                    error_next = nefc_pkg::ST_BAD_LENGTH;
                end
                else if (offset_reg >= nefc_pkg::FIELD_HDR_BYTES - 16'd1)
                begin
                    in_id_next   = in_id_now;
                    id_diff_next = diff_now;
                    // capture nonce and ciphertext lengths behind the header
                    if (!hdr_byte && is_auth && (offset_reg < nefc_pkg::AUTH_LEN_END))
                    begin
                        auth_len_next = {auth_len_reg[23:0], b};
                    end
                    if (field_end)
                    begin
                        if (in_id_now)
                        begin
                            if (field_len < nefc_pkg::ID_MIN_TOTAL)
                            begin
                                error_next = nefc_pkg::ST_ID_SHORT;
                            end
                            else if (diff_now)
                            begin
                                error_next = nefc_pkg::ST_ID_MISMATCH;
                            end
                            else
                            begin
                                seen_id_next = 1'b1;
                            end
                        end
                        else if (is_auth)
                        begin
                            seen_auth_next  = 1'b1;
                            auth_start_next = start_reg;
                        end
                        start_next  = pos_reg + 16'd1;
                        offset_next = '0;
                    end
                    else if (byte_data.final_byte)
                    begin
                        error_next = nefc_pkg::ST_OVERRUN;
                    end
                end
            end
        end

        summary.first_error       = error_next;
        summary.packet_length     = pos_next;
        summary.seen_id           = seen_id_next;
        summary.seen_auth         = seen_auth_next;
        summary.field_start       = start_next;
        summary.field_total       = header_next[15:0];
        summary.nonce_length      = auth_len_next[31:16];
        summary.ciphertext_length = auth_len_next[15:0];
        summary.auth_start        = auth_start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n || push)
        begin
            pos_reg        <= '0;
            start_reg      <= nefc_pkg::HEADER_SKIP;
            offset_reg     <= '0;
            auth_start_reg <= '0;
            header_reg     <= '0;
            auth_len_reg   <= '0;
            in_id_reg      <= 1'b0;
            id_diff_reg    <= 1'b0;
            seen_id_reg    <= 1'b0;
            seen_auth_reg  <= 1'b0;
            error_reg      <= nefc_pkg::ST_OK;
        end
        else
        begin
            pos_reg        <= pos_next;
            start_reg      <= start_next;
            offset_reg     <= offset_next;
            auth_start_reg <= auth_start_next;
            header_reg     <= header_next;
            auth_len_reg   <= auth_len_next;
            in_id_reg      <= in_id_next;
            id_diff_reg    <= id_diff_next;
            seen_id_reg    <= seen_id_next;
            seen_auth_reg  <= seen_auth_next;
            error_reg      <= error_next;
        end
    end

endmodule

// ----- rtl/nefc_queue.sv -----
// Small FIFO of packet summaries between the walker and the result stage
module nefc_queue #(
    parameter int DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  nefc_pkg::summary_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output nefc_pkg::summary_t head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nefc_pkg::summary_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/nefc_back.sv -----
// Result stage: final checks on the authenticator layout and output register
module nefc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   entry_valid,
    input  nefc_pkg::summary_t     entry,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output nefc_pkg::result_item_t result_data
);

    logic                   valid_reg, valid_next;
    nefc_pkg::result_item_t result_reg, result_next;
    nefc_pkg::status_t      status;
    logic [16:0]            nonce_round, ct_round;
    logic [17:0]            body_need;
    logic [15:0]            body_room;

    assign pop          = entry_valid && (!valid_reg || !result_stall);
    assign result_valid = valid_reg;
    assign result_data  = result_reg;

    always_comb
    begin
        nonce_round = ({1'b0, entry.nonce_length} + 17'd3) & ~17'd3;
        ct_round    = ({1'b0, entry.ciphertext_length} + 17'd3) & ~17'd3;
        body_need   = 18'd4 + {1'b0, nonce_round} + {1'b0, ct_round};
        body_room   = entry.field_total - nefc_pkg::FIELD_HDR_BYTES;

        if (entry.first_error != nefc_pkg::ST_OK)
            status = entry.first_error;
        else if (entry.packet_length < nefc_pkg::HEADER_SKIP)
            status = nefc_pkg::ST_SHORT;
        else if (!entry.seen_id)
            status = nefc_pkg::ST_NO_ID;
        else if (!entry.seen_auth)
            status = nefc_pkg::ST_NO_AUTH;
        else if (entry.packet_length != entry.field_start)
            status = nefc_pkg::ST_TRAILING;
        else if (entry.field_total < nefc_pkg::AUTH_MIN_TOTAL)
            status = nefc_pkg::ST_AUTH_SHORT;
        else if (entry.nonce_length < nefc_pkg::NONCE_MIN)
            status = nefc_pkg::ST_NONCE_SHORT;
        else if (entry.ciphertext_length < nefc_pkg::TAG_BYTES)
            status = nefc_pkg::ST_CT_SHORT;
        else if (body_need > {2'b00, body_room})
            status = nefc_pkg::ST_BODY_OVERFLOW;
        else if (entry.ciphertext_length - nefc_pkg::TAG_BYTES > nefc_pkg::PLAINTEXT_LIMIT)
            status = nefc_pkg::ST_PT_TOO_BIG;
        else
            status = nefc_pkg::ST_OK;

        result_next.status        = status;
        result_next.packet_length = entry.packet_length;
        if (status == nefc_pkg::ST_OK)
        begin
            result_next.auth_offset       = entry.auth_start;
            result_next.nonce_length      = entry.nonce_length;
            result_next.ciphertext_length = entry.ciphertext_length;
            result_next.ciphertext_offset = entry.auth_start + 16'd8 + nonce_round[15:0];
        end
        else
        begin
            result_next.auth_offset       = '0;
            result_next.nonce_length      = '0;
            result_next.ciphertext_length = '0;
            result_next.ciphertext_offset = '0;
        end

        // hold while stalled, load on pop, drop after transfer
        if (pop)
            valid_next = 1'b1;
        else if (valid_reg && result_stall)
            valid_next = 1'b1;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule
